[hw/rtl/c_string_escaper_macros.svh]
// ----------------------------------------------------------------------------
// c_string_escaper_macros
// assertion macros used by the escaper checker
// ----------------------------------------------------------------------------
`ifndef C_STRING_ESCAPER_MACROS_SVH
`define C_STRING_ESCAPER_MACROS_SVH

// concurrent check, suspended while reset is high
`define CSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// concurrent check that also holds across reset
`define CSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/cse_pkg.sv]
// ----------------------------------------------------------------------------
// cse_pkg
// types, character codes and helpers for the c string escaper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cse_pkg;

   // most words one item can produce: quote, four-char escape, quote
   localparam int unsigned MAX_WORDS = 6;
   localparam int unsigned CNT_W     = 3;

   localparam logic [7:0] QUOTE_CH  = 8'h22;
   localparam logic [7:0] BSL_CH    = 8'h5C;
   localparam logic [7:0] DOLLAR_CH = 8'h24;
   localparam logic [7:0] BTICK_CH  = 8'h60;
   localparam logic [7:0] BANG_CH   = 8'h21;
   localparam logic [7:0] X_CH      = 8'h78;
   localparam logic [7:0] BEL_CH    = 8'h07;
   localparam logic [7:0] BS_CH     = 8'h08;
   localparam logic [7:0] TAB_CH    = 8'h09;
   localparam logic [7:0] LF_CH     = 8'h0A;
   localparam logic [7:0] VT_CH     = 8'h0B;
   localparam logic [7:0] FF_CH     = 8'h0C;
   localparam logic [7:0] CR_CH     = 8'h0D;
   localparam logic [7:0] NIB_MASK  = 8'h0F;

   // one input word as it sits in the input register
   typedef struct packed {
      logic [7:0] byte_value;
      logic       starts_string;
      logic       ends_string;
      logic       no_char;
   } item_type;

   // the words one item produces, first word in entry 0
   typedef struct packed {
      logic [MAX_WORDS-1:0][7:0] bytes;
      logic [CNT_W-1:0]          count;
   } run_type;

   // uppercase hex digit of the low nibble
   function automatic logic [7:0] hex_digit(input logic [7:0] v);
      logic [7:0] n;
      n = v & NIB_MASK;
      if (n < 8'd10) begin
         hex_digit = 8'h30 + n;
      end else begin
         hex_digit = 8'h37 + n;
      end
   endfunction

endpackage

[hw/rtl/cse_encode.sv]
// ----------------------------------------------------------------------------
// cse_encode
// turns one buffered item into its run of literal words, keeps the hex flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_encode (
   input  logic              clock,
   input  logic              reset,
   input  cse_pkg::item_type item,
   input  logic              commit,
   output cse_pkg::run_type  run
);

   logic       hex_pending_ff;
   logic       hex_pending_in;

   // escape classification and the character part of the run
   always_comb begin
      logic       h0;
      logic [7:0] b;
      logic [7:0] named;
      logic       is_named;
      logic       is_hexdig;
      logic       is_print;
      logic       use_hex;
      logic [3:0][7:0] c;
      logic [cse_pkg::CNT_W-1:0] clen;
      logic [cse_pkg::CNT_W-1:0] s;
      logic [cse_pkg::CNT_W-1:0] e;
      logic [cse_pkg::CNT_W-1:0] j;

      b        = item.byte_value;
      h0       = item.starts_string ? 1'b0 : hex_pending_ff;
      named    = 8'h00;
      is_named = 1'b1;
      use_hex  = 1'b0;
      case (b)
         cse_pkg::BEL_CH:    named = 8'h61;
         cse_pkg::BS_CH:     named = 8'h62;
         cse_pkg::FF_CH:     named = 8'h66;
         cse_pkg::LF_CH:     named = 8'h6E;
         cse_pkg::CR_CH:     named = 8'h72;
         cse_pkg::TAB_CH:    named = 8'h74;
         cse_pkg::VT_CH:     named = 8'h76;
         cse_pkg::QUOTE_CH:  named = cse_pkg::QUOTE_CH;
         cse_pkg::BSL_CH:    named = cse_pkg::BSL_CH;
         cse_pkg::DOLLAR_CH,
         cse_pkg::BTICK_CH,
         cse_pkg::BANG_CH: begin
            is_named = 1'b0;
            use_hex  = 1'b1;
         end
         default:            is_named = 1'b0;
      endcase

      is_hexdig = b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
      is_print  = b inside {[8'h20:8'h7E]};
      if (!is_named && !use_hex) begin
         use_hex = is_hexdig ? h0 : !is_print;
      end

      // character words and the flag they leave behind
      c              = '0;
      clen           = '0;
      hex_pending_in = h0;
      if (!item.no_char) begin
         if (is_named) begin
            c[0] = cse_pkg::BSL_CH;
            c[1] = named;
            clen = 3'd2;
         end else if (use_hex) begin
            c[0] = cse_pkg::BSL_CH;
            c[1] = cse_pkg::X_CH;
            c[2] = cse_pkg::hex_digit(b >> 4);
            c[3] = cse_pkg::hex_digit(b);
            clen = 3'd4;
            hex_pending_in = 1'b1;
         end else begin
            c[0] = b;
            clen = 3'd1;
            hex_pending_in = 1'b0;
         end
      end

      // place quotes around the character words
      s = {2'b00, item.starts_string};
      e = {2'b00, item.ends_string};
      for (int i = 0; i < cse_pkg::MAX_WORDS; i++) begin
         j = 3'(i) - s;
         if (item.starts_string && i == 0) begin
            run.bytes[i] = cse_pkg::QUOTE_CH;
         end else if (j < clen) begin
            run.bytes[i] = c[j[1:0]];
         end else begin
            run.bytes[i] = cse_pkg::QUOTE_CH;
         end
      end
      run.count = s + clen + e;
   end

   // hex flag moves on when the item is handed on
   always_ff @(posedge clock) begin
      if (reset) begin
         hex_pending_ff <= 1'b0;
      end else if (commit) begin
         hex_pending_ff <= hex_pending_in;
      end
   end

endmodule

[hw/rtl/cse_serializer.sv]
// ----------------------------------------------------------------------------
// cse_serializer
// holds one run of words and sends them out one word per cycle while rsp_tready is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_serializer (
   input  logic             clock,
   input  logic             reset,
   input  cse_pkg::run_type run,
   input  logic             load,
   output logic             can_load,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte[7:0]
   output logic             rsp_tlast    // last_of_run
);

   logic [cse_pkg::MAX_WORDS-1:0][7:0] bytes_ff;
   logic [cse_pkg::CNT_W-1:0]          count_ff;
   logic [cse_pkg::CNT_W-1:0]          idx_ff;
   logic                               valid_ff;
   logic                               last;

   // current word and free slot
   assign last       = (idx_ff == count_ff - 3'd1);
   assign can_load   = !valid_ff || (rsp_tready && last);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = bytes_ff[idx_ff];
   assign rsp_tlast  = last;

   // run buffer payload
   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= run.bytes;
         count_ff <= run.count;
      end
   end

   // word pointer and valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (valid_ff && rsp_tready) begin
         if (last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

endmodule

[hw/rtl/c_string_escaper.sv]
// ----------------------------------------------------------------------------
// c_string_escaper
// streaming escaper from raw string bytes to a quoted c literal
// ----------------------------------------------------------------------------
// Each input word carries one raw byte plus start, end and no-character
// flags; the block sends the quoted, escaped literal one output byte per
// word, tlast marking the last byte that input word caused. An input word
// gives 0 to 6 output words: a plain byte 1, a named escape 2, a hex escape
// 4, plus one per quote. The output port moves one word per cycle while
// rsp_tready is high and sets the sustained rate: a word costs as many
// output transfers as output words it makes, while words with no output
// pass without using the output port. Input is taken every cycle as long
// as the output keeps up; a word is held in the input register, then its
// run is held in the output run buffer until its last byte is taken.
`timescale 1ns / 1ps

module c_string_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // byte_value[7:0]
   input  logic [1:0] req_tuser,   // [1] no_char, [0] starts_string
   input  logic       req_tlast,   // ends_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte[7:0]
   output logic       rsp_tlast    // last_of_run
);

   cse_pkg::item_type item_ff;
   cse_pkg::run_type  run;
   logic              item_valid_ff;
   logic              commit;
   logic              can_load;
   logic              load;
   logic              req_fire;

   // hand the buffered word on when its run fits or it makes no output
   assign commit     = item_valid_ff && (run.count == '0 || can_load);
   assign load       = commit && (run.count != '0);
   assign req_tready = !item_valid_ff || commit;
   assign req_fire   = req_tvalid && req_tready;

   // input register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.byte_value    <= req_tdata;
         item_ff.starts_string <= req_tuser[0];
         item_ff.ends_string   <= req_tlast;
         item_ff.no_char       <= req_tuser[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_fire) begin
         item_valid_ff <= 1'b1;
      end else if (commit) begin
         item_valid_ff <= 1'b0;
      end
   end

   // escape logic and hex flag
   cse_encode u_encode (
      .clock  (clock),
      .reset  (reset),
      .item   (item_ff),
      .commit (commit),
      .run    (run)
   );

   // output run buffer
   cse_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .run        (run),
      .load       (load),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hw/rtl/cse_checker.sv]
// ----------------------------------------------------------------------------
// cse_checker
// port-level checks on the c string escaper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "c_string_escaper_macros.svh"

module cse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled output word holds still
   `CSE_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "output word changed while stalled")

   // nothing leaves the block right after reset
   `CSE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "output valid after reset")

   // input only backs up when output is pending
   `CSE_ASSERT(a_ready_backpressure, clock, reset, !req_tready |-> rsp_tvalid, "input stalled with no output pending")

   // every literal byte is printable and never a shell-sensitive character
   `CSE_ASSERT(a_printable, clock, reset, rsp_tvalid |-> rsp_tdata >= 8'h20 && rsp_tdata <= 8'h7E && rsp_tdata != 8'h24 && rsp_tdata != 8'h60 && rsp_tdata != 8'h21, "unescaped byte in output")

endmodule

bind c_string_escaper cse_checker u_cse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
